FILE: design/fpba_pkg.sv
// shared types and codes for the fit policy block allocator
package fpba_pkg;

    localparam int OFF_W  = 27;
    localparam int SIZE_W = 28;
    localparam int CNT_OUT_W = 7;

    localparam logic [SIZE_W-1:0] POOL_MIN   = 28'd64;
    localparam logic [SIZE_W-1:0] POOL_MAX   = 28'd134217728;
    localparam logic [SIZE_W-1:0] POOL_RESET = 28'd1048576;

    // command codes
    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // fit policy codes
    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO     = 2'd1;
    localparam logic [1:0] ST_NO_FIT   = 2'd2;
    localparam logic [1:0] ST_BAD_OFF  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_FIT_POLICY = 2'd0;
    localparam logic [1:0] REG_POOL_BYTES = 2'd1;

    // one block table entry
    typedef struct packed {
        logic              used;
        logic [SIZE_W-1:0] size;
        logic [OFF_W-1:0]  off;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_SCAN_RD,
        S_SCAN_EV,
        S_ALLOC,
        S_NEXT_RD,
        S_NEXT_EV,
        S_REL,
        S_SH_RD,
        S_SH_WR,
        S_FIX1,
        S_FIX2,
        S_FINISH
    } state_t;

endpackage

FILE: design/fpba_ram.sv
// generic single write port ram with registered read
module fpba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: design/fit_policy_block_allocator.sv
// top level of the fit policy block allocator
//
// Keeps one pool as an address-ordered table of blocks in a single ram.
// Input words on s_axis carry an allocate or release command; each word
// gives exactly one result word on m_axis with status, grant and usage.
// A sequencer walks the table one entry at a time, a read step then an
// evaluate step, through the single ram read port: a scan to find the block,
// then a shift of the entries behind it to insert or remove, then one or two
// fix-up writes.
// s_axis_tready is high only while idle.
// The result sits in an output register; a new word is accepted while it
// waits, and the sequencer holds in its last step while m_axis stalls.
// Reset, and any write of pool_bytes, stores the single free block in the
// init state; cfg writes are taken at any edge with cfg_we high.
module fit_policy_block_allocator #(
    parameter int MAX_BLOCKS  = 64,
    parameter int SPLIT_SLACK = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    // configuration
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [27:0]  cfg_data,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [55:0]  s_axis_tdata,  // request_size, release_offset, pad
    input  logic [0:0]   s_axis_tuser,  // command
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata   // status, granted_offset, granted_size,
                                        // used_bytes, block_count,
                                        // free_block_count, pad
);

    import fpba_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int WANT_W = SIZE_W + 1;
    localparam int CMP_W = SIZE_W + 2;

    state_t state_reg, state_next;

    logic              cmd_reg, cmd_next;
    logic [WANT_W-1:0] want_reg, want_next;
    logic [OFF_W-1:0]  roff_reg, roff_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              found_reg, found_next;
    logic [CNT_W-1:0]  sel_reg, sel_next;
    entry_t            sel_ent_reg, sel_ent_next;
    entry_t            prev_ent_reg, prev_ent_next;
    entry_t            nxt_ent_reg, nxt_ent_next;
    logic              has_nxt_reg, has_nxt_next;
    logic              split_reg, split_next;
    logic              dir_up_reg, dir_up_next;
    logic [1:0]        dist_reg, dist_next;
    logic [CNT_W-1:0]  dst_reg, dst_next;
    logic [CNT_W-1:0]  lim_reg, lim_next;
    logic [CNT_W-1:0]  fix_addr_reg, fix_addr_next;
    entry_t            fix_ent_reg, fix_ent_next;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  free_reg, free_next;
    logic [SIZE_W-1:0] used_reg, used_next;
    logic [1:0]        fit_reg, fit_next;
    logic [SIZE_W-1:0] pool_reg, pool_next;

    logic [1:0]        status_reg, status_next;
    logic [OFF_W-1:0]  goff_reg, goff_next;
    logic [SIZE_W-1:0] gsize_reg, gsize_next;

    logic              mvalid_reg, mvalid_next;
    logic [103:0]      mdata_reg, mdata_next;

    // ram port signals
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    entry_t            ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t            rd_ent;

    assign rd_ent = entry_t'(ram_rdata);

    fpba_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = mdata_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            count_reg  <= CNT_W'(1);
            free_reg   <= CNT_W'(1);
            used_reg   <= '0;
            fit_reg    <= FIT_FIRST;
            pool_reg   <= POOL_RESET;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            free_reg   <= free_next;
            used_reg   <= used_next;
            fit_reg    <= fit_next;
            pool_reg   <= pool_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        want_reg     <= want_next;
        roff_reg     <= roff_next;
        idx_reg      <= idx_next;
        found_reg    <= found_next;
        sel_reg      <= sel_next;
        sel_ent_reg  <= sel_ent_next;
        prev_ent_reg <= prev_ent_next;
        nxt_ent_reg  <= nxt_ent_next;
        has_nxt_reg  <= has_nxt_next;
        split_reg    <= split_next;
        dir_up_reg   <= dir_up_next;
        dist_reg     <= dist_next;
        dst_reg      <= dst_next;
        lim_reg      <= lim_next;
        fix_addr_reg <= fix_addr_next;
        fix_ent_reg  <= fix_ent_next;
        status_reg   <= status_next;
        goff_reg     <= goff_next;
        gsize_reg    <= gsize_next;
        mdata_reg    <= mdata_next;
    end

    // sequencer
    always_comb
    begin
        logic [WANT_W-1:0] req_ext;
        logic              fits;
        logic              take;
        logic              last;
        logic              nxt_free;
        logic              prv_free;
        logic [CNT_W-1:0]  shp;
        logic [SIZE_W-1:0] sz;
        logic [SIZE_W-1:0] clamp;
        logic [CNT_W-1:0]  dst_new;

        req_ext  = '0;
        fits     = 1'b0;
        take     = 1'b0;
        last     = 1'b0;
        nxt_free = 1'b0;
        prv_free = 1'b0;
        shp      = '0;
        sz       = '0;
        clamp    = '0;
        dst_new  = '0;

        state_next    = state_reg;
        cmd_next      = cmd_reg;
        want_next     = want_reg;
        roff_next     = roff_reg;
        idx_next      = idx_reg;
        found_next    = found_reg;
        sel_next      = sel_reg;
        sel_ent_next  = sel_ent_reg;
        prev_ent_next = prev_ent_reg;
        nxt_ent_next  = nxt_ent_reg;
        has_nxt_next  = has_nxt_reg;
        split_next    = split_reg;
        dir_up_next   = dir_up_reg;
        dist_next     = dist_reg;
        dst_next      = dst_reg;
        lim_next      = lim_reg;
        fix_addr_next = fix_addr_reg;
        fix_ent_next  = fix_ent_reg;
        count_next    = count_reg;
        free_next     = free_reg;
        used_next     = used_reg;
        fit_next      = fit_reg;
        pool_next     = pool_reg;
        status_next   = status_reg;
        goff_next     = goff_reg;
        gsize_next    = gsize_reg;
        mvalid_next   = mvalid_reg;
        mdata_next    = mdata_reg;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;

        // result handed off
        if (mvalid_reg && m_axis_tready)
        begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    req_ext     = WANT_W'(s_axis_tdata[27:0]);
                    cmd_next    = s_axis_tuser[0];
                    want_next   = (req_ext + WANT_W'(7)) & ~WANT_W'(7);
                    roff_next   = s_axis_tdata[54:28];
                    idx_next    = '0;
                    found_next  = 1'b0;
                    status_next = ST_OK;
                    goff_next   = '0;
                    gsize_next  = '0;
                    split_next  = 1'b0;
                    if (s_axis_tuser[0] == CMD_ALLOC && s_axis_tdata[27:0] == '0)
                    begin
                        status_next = ST_ZERO;
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
            end

            S_INIT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = '{used: 1'b0, size: pool_reg, off: '0};
                state_next = S_IDLE;
            end

            S_SCAN_RD:
            begin
                ram_raddr  = idx_reg[IDX_W-1:0];
                state_next = S_SCAN_EV;
            end

            S_SCAN_EV:
            begin
                last = (idx_reg + CNT_W'(1) == count_reg);
                idx_next = idx_reg + CNT_W'(1);
                if (cmd_reg == CMD_ALLOC)
                begin
                    fits = !rd_ent.used && (WANT_W'(rd_ent.size) >= want_reg);
                    take = fits && (!found_reg
                        || (fit_reg == FIT_BEST && rd_ent.size < sel_ent_reg.size)
                        || (fit_reg == FIT_WORST && rd_ent.size > sel_ent_reg.size));
                    if (take)
                    begin
                        found_next   = 1'b1;
                        sel_next     = idx_reg;
                        sel_ent_next = rd_ent;
                    end
                    if (last || (fits && !found_reg && fit_reg != FIT_BEST
                                 && fit_reg != FIT_WORST))
                    begin
                        state_next = S_ALLOC;
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
                else
                begin
                    if (rd_ent.used && rd_ent.off == roff_reg)
                    begin
                        sel_next     = idx_reg;
                        sel_ent_next = rd_ent;
                        has_nxt_next = (idx_reg + CNT_W'(1) < count_reg);
                        if (idx_reg + CNT_W'(1) < count_reg)
                        begin
                            state_next = S_NEXT_RD;
                        end
                        else
                        begin
                            state_next = S_REL;
                        end
                    end
                    else
                    begin
                        prev_ent_next = rd_ent;
                        if (last)
                        begin
                            status_next = ST_BAD_OFF;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                end
            end

            S_ALLOC:
            begin
                if (!found_reg)
                begin
                    status_next = ST_NO_FIT;
                    state_next  = S_FINISH;
                end
                else
                begin
                    split_next = (CMP_W'(sel_ent_reg.size) > CMP_W'(want_reg)
                                  + CMP_W'(SPLIT_SLACK))
                                 && (count_reg < CNT_W'(MAX_BLOCKS));
                    sz = split_next ? want_reg[SIZE_W-1:0] : sel_ent_reg.size;
                    fix_addr_next = sel_reg;
                    fix_ent_next  = '{used: 1'b1, size: sz, off: sel_ent_reg.off};
                    goff_next     = sel_ent_reg.off;
                    gsize_next    = sz;
                    used_next     = used_reg + sz;
                    if (split_next)
                    begin
                        count_next  = count_reg + CNT_W'(1);
                        dir_up_next = 1'b1;
                        dst_next    = count_reg;
                        if (count_reg > sel_reg + CNT_W'(1))
                        begin
                            state_next = S_SH_RD;
                        end
                        else
                        begin
                            state_next = S_FIX1;
                        end
                    end
                    else
                    begin
                        free_next  = free_reg - CNT_W'(1);
                        state_next = S_FIX2;
                    end
                end
            end

            S_NEXT_RD:
            begin
                ram_raddr  = IDX_W'(sel_reg + CNT_W'(1));
                state_next = S_NEXT_EV;
            end

            S_NEXT_EV:
            begin
                nxt_ent_next = rd_ent;
                state_next   = S_REL;
            end

            S_REL:
            begin
                nxt_free = has_nxt_reg && !nxt_ent_reg.used;
                prv_free = (sel_reg != '0) && !prev_ent_reg.used;
                used_next = (used_reg >= sel_ent_reg.size) ? used_reg - sel_ent_reg.size
                                                           : '0;
                lim_next    = count_reg;
                dir_up_next = 1'b0;
                dist_next   = 2'd1;
                shp         = sel_reg;
                fix_addr_next = sel_reg;
                fix_ent_next  = '{used: 1'b0, size: sel_ent_reg.size,
                                  off: sel_ent_reg.off};
                priority if (nxt_free && prv_free)
                begin
                    fix_addr_next = sel_reg - CNT_W'(1);
                    fix_ent_next  = '{used: 1'b0,
                                      size: prev_ent_reg.size + sel_ent_reg.size
                                            + nxt_ent_reg.size,
                                      off: prev_ent_reg.off};
                    dist_next  = 2'd2;
                    count_next = count_reg - CNT_W'(2);
                    free_next  = free_reg - CNT_W'(1);
                end
                else if (prv_free)
                begin
                    fix_addr_next = sel_reg - CNT_W'(1);
                    fix_ent_next  = '{used: 1'b0,
                                      size: prev_ent_reg.size + sel_ent_reg.size,
                                      off: prev_ent_reg.off};
                    count_next = count_reg - CNT_W'(1);
                end
                else if (nxt_free)
                begin
                    fix_ent_next.size = sel_ent_reg.size + nxt_ent_reg.size;
                    shp        = sel_reg + CNT_W'(1);
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    free_next = free_reg + CNT_W'(1);
                end
                dst_next = shp;
                if ((nxt_free || prv_free)
                    && (shp + CNT_W'(dist_next) < count_reg))
                begin
                    state_next = S_SH_RD;
                end
                else
                begin
                    state_next = S_FIX2;
                end
            end

            S_SH_RD:
            begin
                if (dir_up_reg)
                begin
                    ram_raddr = IDX_W'(dst_reg - CNT_W'(1));
                end
                else
                begin
                    ram_raddr = IDX_W'(dst_reg + CNT_W'(dist_reg));
                end
                state_next = S_SH_WR;
            end

            S_SH_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = dst_reg[IDX_W-1:0];
                ram_wdata = rd_ent;
                if (dir_up_reg)
                begin
                    dst_new = dst_reg - CNT_W'(1);
                    if (dst_new > sel_reg + CNT_W'(1))
                    begin
                        state_next = S_SH_RD;
                    end
                    else
                    begin
                        state_next = split_reg ? S_FIX1 : S_FIX2;
                    end
                end
                else
                begin
                    dst_new = dst_reg + CNT_W'(1);
                    if (dst_new + CNT_W'(dist_reg) < lim_reg)
                    begin
                        state_next = S_SH_RD;
                    end
                    else
                    begin
                        state_next = S_FIX2;
                    end
                end
                dst_next = dst_new;
            end

            S_FIX1:
            begin
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(sel_reg + CNT_W'(1));
                ram_wdata = '{used: 1'b0,
                              size: sel_ent_reg.size - want_reg[SIZE_W-1:0],
                              off: sel_ent_reg.off + want_reg[OFF_W-1:0]};
                state_next = S_FIX2;
            end

            S_FIX2:
            begin
                ram_we     = 1'b1;
                ram_waddr  = fix_addr_reg[IDX_W-1:0];
                ram_wdata  = fix_ent_reg;
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (!mvalid_reg || m_axis_tready)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = {5'd0,
                                   CNT_OUT_W'(free_reg),
                                   CNT_OUT_W'(count_reg),
                                   used_reg,
                                   gsize_reg,
                                   goff_reg,
                                   status_reg};
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // configuration writes
        if (cfg_we)
        begin
            if (cfg_index == REG_FIT_POLICY)
            begin
                fit_next = cfg_data[1:0];
            end
            else if (cfg_index == REG_POOL_BYTES)
            begin
                clamp = cfg_data;
                if (clamp < POOL_MIN)
                begin
                    clamp = POOL_MIN;
                end
                if (clamp > POOL_MAX)
                begin
                    clamp = POOL_MAX;
                end
                pool_next  = clamp;
                count_next = CNT_W'(1);
                free_next  = CNT_W'(1);
                used_next  = '0;
                state_next = S_INIT;
            end
        end
    end

endmodule

FILE: tb/tb_fit_policy_block_allocator.sv
// self-checking testbench for the fit policy block allocator
module tb_fit_policy_block_allocator;

    timeunit 1ns;
    timeprecision 1ps;

    import fpba_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int SLACK       = 64;

    typedef struct packed {
        logic              cmd;
        logic [SIZE_W-1:0] req;
        logic [OFF_W-1:0]  off;
    } request_t;

    // lowest field last so that status lands in the low bits
    typedef struct packed {
        logic [CNT_OUT_W-1:0] nfree;
        logic [CNT_OUT_W-1:0] nblk;
        logic [SIZE_W-1:0]    used;
        logic [SIZE_W-1:0]    gsize;
        logic [OFF_W-1:0]     goff;
        logic [1:0]           status;
    } outcome_t;

    logic          clk;
    logic          rst_n;
    logic          cfg_we;
    logic [1:0]    cfg_index;
    logic [27:0]   cfg_data;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [55:0]   s_axis_tdata;   // request_size, release_offset, pad
    logic [0:0]    s_axis_tuser;   // command
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [103:0]  m_axis_tdata;   // status, granted_offset, granted_size,
                                   // used_bytes, block_count, free_block_count

    fit_policy_block_allocator dut (.*);

    // allocator shadow state
    logic [OFF_W-1:0]  sh_off  [TABLE_DEPTH];
    logic [SIZE_W-1:0] sh_size [TABLE_DEPTH];
    logic              sh_used [TABLE_DEPTH];
    int unsigned       sh_count;
    logic [SIZE_W-1:0] sh_used_total;
    logic [1:0]        sh_policy;
    logic [SIZE_W-1:0] sh_pool;

    request_t    pending_words[$];
    outcome_t    expected_results[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned words_sent;
    int unsigned hold_off;
    bit          hold_go;
    bit          hold_armed;
    bit          stimulus_done;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic void table_clear();
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            sh_off[i]  = '0;
            sh_size[i] = '0;
            sh_used[i] = 1'b0;
        end
        sh_size[0]    = sh_pool;
        sh_count      = 1;
        sh_used_total = '0;
    endfunction

    function automatic void drop_entry(int unsigned k);
        if (k >= sh_count || sh_count <= 1)
            return;
        for (int unsigned j = k; j + 1 < sh_count; j++)
        begin
            sh_off[j]  = sh_off[j+1];
            sh_size[j] = sh_size[j+1];
            sh_used[j] = sh_used[j+1];
        end
        sh_count--;
        sh_off[sh_count]  = '0;
        sh_size[sh_count] = '0;
        sh_used[sh_count] = 1'b0;
    endfunction

    // compute the result of one request and update the shadow table
    function automatic outcome_t allocate_or_release(request_t w);
        outcome_t    r;
        int unsigned n;
        int unsigned sel;
        int unsigned k;
        bit          found;
        logic [SIZE_W:0] want;
        r     = '0;
        n     = sh_count;
        sel   = 0;
        k     = 0;
        found = 0;
        if (w.cmd == CMD_ALLOC)
        begin
            if (w.req == 0)
                r.status = ST_ZERO;
            else
            begin
                want = ({1'b0, w.req} + 29'd7) & ~29'd7;
                for (int unsigned i = 0; i < n; i++)
                begin
                    if (sh_used[i] || sh_size[i] < want)
                        continue;
                    if (!found)
                    begin
                        found = 1;
                        sel   = i;
                        if (sh_policy != FIT_BEST && sh_policy != FIT_WORST)
                            break;
                    end
                    else if (sh_policy == FIT_BEST && sh_size[i] < sh_size[sel])
                        sel = i;
                    else if (sh_policy == FIT_WORST && sh_size[i] > sh_size[sel])
                        sel = i;
                end
                if (!found)
                    r.status = ST_NO_FIT;
                else
                begin
                    if (sh_size[sel] > want + SLACK && n < TABLE_DEPTH)
                    begin
                        for (int unsigned j = n; j > sel + 1; j--)
                        begin
                            sh_off[j]  = sh_off[j-1];
                            sh_size[j] = sh_size[j-1];
                            sh_used[j] = sh_used[j-1];
                        end
                        sh_off[sel+1]  = sh_off[sel] + want[OFF_W-1:0];
                        sh_size[sel+1] = sh_size[sel] - want[SIZE_W-1:0];
                        sh_used[sel+1] = 1'b0;
                        sh_size[sel]   = want[SIZE_W-1:0];
                        sh_count       = n + 1;
                    end
                    sh_used[sel]  = 1'b1;
                    sh_used_total = sh_used_total + sh_size[sel];
                    r.goff        = sh_off[sel];
                    r.gsize       = sh_size[sel];
                end
            end
        end
        else
        begin
            for (int unsigned i = 0; i < n; i++)
                if (sh_used[i] && sh_off[i] == w.off)
                begin
                    found = 1;
                    k     = i;
                    break;
                end
            if (!found)
                r.status = ST_BAD_OFF;
            else
            begin
                sh_used[k] = 1'b0;
                sh_used_total = (sh_used_total >= sh_size[k]) ?
                                sh_used_total - sh_size[k] : '0;
                if (k + 1 < sh_count && !sh_used[k+1])
                begin
                    sh_size[k] = sh_size[k] + sh_size[k+1];
                    drop_entry(k + 1);
                end
                if (k > 0 && !sh_used[k-1])
                begin
                    sh_size[k-1] = sh_size[k-1] + sh_size[k];
                    drop_entry(k);
                end
            end
        end
        r.used = sh_used_total;
        r.nblk = CNT_OUT_W'(sh_count);
        for (int unsigned i = 0; i < sh_count; i++)
            if (!sh_used[i])
                r.nfree++;
        return r;
    endfunction

    // pick an offset of some used block, or a random one now and then
    function automatic logic [OFF_W-1:0] some_used_offset();
        int unsigned cand[$];
        for (int unsigned i = 0; i < sh_count; i++)
            if (sh_used[i])
                cand.push_back(i);
        if (cand.size() == 0 || $urandom_range(9) == 0)
            return OFF_W'($urandom);
        return sh_off[cand[$urandom_range(cand.size() - 1)]];
    endfunction

    // input driver with random gaps
    int unsigned send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            send_gap      <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(allocate_or_release(pending_words.pop_front()));
                words_sent++;
            end
            if (s_axis_tvalid && !s_axis_tready)
                ;
            else if (send_gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                send_gap      <= send_gap - 1;
            end
            else if (pending_words.size() != 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= pending_words[0].cmd;
                s_axis_tdata  <= {1'b0, pending_words[0].off, pending_words[0].req};
                send_gap      <= ($urandom_range(3) == 0) ? 0 : $urandom_range(17);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // long receiver hold-off, counted once after it is requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off   <= 0;
            hold_armed <= 1'b0;
        end
        else if (hold_go && !hold_armed)
        begin
            hold_off   <= 400;
            hold_armed <= 1'b1;
        end
        else if (hold_off != 0)
            hold_off <= hold_off - 1;
    end

    // result monitor with random stalls and a long hold-off
    int unsigned stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        outcome_t got;
        outcome_t exp;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[$bits(outcome_t)-1:0];
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result word %h", $time, got);
                    mismatches++;
                end
                else
                begin
                    exp = expected_results.pop_front();
                    if (got.status !== exp.status)
                        $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
                    if (got.goff !== exp.goff)
                        $display("%0t: granted_offset exp %0d got %0d", $time, exp.goff, got.goff);
                    if (got.gsize !== exp.gsize)
                        $display("%0t: granted_size exp %0d got %0d", $time, exp.gsize, got.gsize);
                    if (got.used !== exp.used)
                        $display("%0t: used_bytes exp %0d got %0d", $time, exp.used, got.used);
                    if (got.nblk !== exp.nblk)
                        $display("%0t: block_count exp %0d got %0d", $time, exp.nblk, got.nblk);
                    if (got.nfree !== exp.nfree)
                        $display("%0t: free_block_count exp %0d got %0d", $time, exp.nfree,
                                 got.nfree);
                    if (got !== exp)
                        mismatches++;
                end
            end
            if (hold_off != 0)
            begin
                m_axis_tready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left    <= stall_left - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (m_axis_tvalid && m_axis_tready)
                    stall_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(17);
            end
        end
    end

    task automatic wait_drained();
        while (pending_words.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [27:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_FIT_POLICY)
            sh_policy = val[1:0];
        else if (idx == REG_POOL_BYTES)
        begin
            sh_pool = (val < POOL_MIN) ? POOL_MIN : (val > POOL_MAX) ? POOL_MAX : val;
            table_clear();
        end
        @(posedge clk);
    endtask

    function automatic request_t alloc_word(logic [SIZE_W-1:0] sz);
        request_t w;
        w     = '0;
        w.cmd = CMD_ALLOC;
        w.req = sz;
        w.off = OFF_W'($urandom);
        return w;
    endfunction

    function automatic request_t release_word(logic [OFF_W-1:0] o);
        request_t w;
        w     = '0;
        w.cmd = CMD_RELEASE;
        w.off = o;
        w.req = SIZE_W'($urandom);
        return w;
    endfunction

    // random sizes: mostly small against the pool, some huge
    function automatic logic [SIZE_W-1:0] random_size();
        case ($urandom_range(9))
            0:       return SIZE_W'($urandom);
            1:       return SIZE_W'($urandom_range(8));
            2:       return sh_pool >> $urandom_range(3);
            default: return SIZE_W'($urandom_range(1, (sh_pool >> 4) + 1));
        endcase
    endfunction

    // release offsets are chosen from the shadow table, so words are queued one at a time
    task automatic run_random(int unsigned count, int unsigned rel_pct);
        for (int unsigned i = 0; i < count; i++)
        begin
            while (pending_words.size() != 0 || expected_results.size() != 0)
                @(posedge clk);
            if ($urandom_range(99) < rel_pct)
                pending_words.push_back(release_word(some_used_offset()));
            else
                pending_words.push_back(alloc_word(random_size()));
        end
    endtask

    initial
    begin
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        rst_n         = 1'b0;
        hold_go       = 1'b0;
        mismatches    = 0;
        results_seen  = 0;
        words_sent    = 0;
        stimulus_done = 0;
        sh_policy     = FIT_FIRST;
        sh_pool       = POOL_RESET;
        table_clear();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // directed: extremes, zero size, oversize, bad releases, merges
        pending_words.push_back(alloc_word('0));
        pending_words.push_back(alloc_word(28'd1));
        pending_words.push_back(alloc_word(28'd100));
        pending_words.push_back(alloc_word(28'd200));
        pending_words.push_back(alloc_word(28'hFFFFFFF));
        pending_words.push_back(alloc_word(POOL_MAX));
        pending_words.push_back(release_word(27'd8));
        pending_words.push_back(release_word(27'h7FFFFFF));
        pending_words.push_back(release_word(27'd0));
        pending_words.push_back(release_word(27'd0));
        pending_words.push_back(release_word(27'd8));
        pending_words.push_back(release_word(27'd112));
        pending_words.push_back(alloc_word(28'd1048576));
        pending_words.push_back(release_word(27'd0));
        wait_drained();

        // full pool, many tiny blocks to fill the table, odd policy
        write_reg(REG_POOL_BYTES, 28'hFFFFFFF);
        write_reg(REG_FIT_POLICY, 2'd3);
        for (int i = 0; i < 70; i++)
            pending_words.push_back(alloc_word(28'd8));
        pending_words.push_back(alloc_word(28'd1));
        wait_drained();

        // receiver holds off while the sender keeps offering a queued batch
        hold_go = 1'b1;
        for (int i = 0; i < 30; i++)
        begin
            if ($urandom_range(99) < 40)
                pending_words.push_back(release_word(some_used_offset()));
            else
                pending_words.push_back(alloc_word(random_size()));
        end
        wait_drained();

        write_reg(REG_POOL_BYTES, 28'd0);
        write_reg(2'd2, 28'd5);
        write_reg(2'd3, 28'd5);
        run_random(40, 40);
        wait_drained();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_FIT_POLICY, 28'(ph % 3));
            case (ph)
                0:       write_reg(REG_POOL_BYTES, 28'd64);
                1:       write_reg(REG_POOL_BYTES, POOL_MAX);
                2:       write_reg(REG_POOL_BYTES, 28'd4096);
                default: write_reg(REG_POOL_BYTES, 28'($urandom_range(64, 1 << 20)));
            endcase
            run_random(90, 45);
            wait_drained();
        end
        stimulus_done = 1;
        $display("run covered %0d words across all fit policies and pool sizes,", words_sent);
        $display("including full-table grants, merges and bad releases; %0d results checked",
                 results_seen);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

endmodule

FILE: fit_policy_block_allocator.f
design/fpba_pkg.sv
design/fpba_ram.sv
design/fit_policy_block_allocator.sv
tb/tb_fit_policy_block_allocator.sv
